// File: rtl/core/slxfp_pkg.sv
// Shared types and constants for the sync/length/XOR frame parser.
`timescale 1ns / 1ps

package slxfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam logic [7:0]  MAX_LEN_RESET       = 8'd255;

  // item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHK   = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  // output tdata layout
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       chk_ok;
    logic [7:0] len;
  } entry_t;

endpackage

// File: rtl/core/slxfp_front.sv
// Front end: sync hunt, length capture, running XOR, word classification.
`timescale 1ns / 1ps

module slxfp_front
  import slxfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  logic [2:0] phase, phase_next;
  logic [7:0] exp_len, exp_len_next;
  logic [7:0] count, count_next;
  logic [7:0] run_xor, run_xor_next;
  logic       accept;
  logic [7:0] count_inc;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign count_inc = count + 8'd1;

  always_comb begin
    phase_next   = phase;
    exp_len_next = exp_len;
    count_next   = count;
    run_xor_next = run_xor;
    push         = 1'b0;
    push_entry   = '0;
    if (accept) begin
      unique case (phase)
        PH_SYNC2: begin
          if (in_byte == SYNC_SECOND) begin
            run_xor_next = SYNC_FIRST ^ SYNC_SECOND;
            phase_next   = PH_LEN;
          end else if (in_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN: begin
          exp_len_next = in_byte;
          count_next   = 8'd0;
          run_xor_next = run_xor ^ in_byte;
          phase_next   = (in_byte == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          run_xor_next    = run_xor ^ in_byte;
          count_next      = count_inc;
          if (count_inc == exp_len) phase_next = PH_CHECK;
          push            = 1'b1;
          push_entry.kind = KIND_PAYLOAD;
          push_entry.data = in_byte;
        end
        PH_CHECK: begin
          push              = 1'b1;
          push_entry.kind   = KIND_STATUS;
          push_entry.chk_ok = (in_byte == run_xor);
          push_entry.len    = exp_len;
          phase_next        = PH_HUNT;
        end
        default: begin
          phase_next = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      exp_len <= 8'd0;
      count   <= 8'd0;
      run_xor <= 8'd0;
    end else begin
      phase   <= phase_next;
      exp_len <= exp_len_next;
      count   <= count_next;
      run_xor <= run_xor_next;
    end
  end

endmodule

// File: rtl/core/slxfp_queue.sv
// Short FIFO of classified words between front and back end.
`timescale 1ns / 1ps

module slxfp_queue
  import slxfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push, do_pop;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      fill <= fill + CNT_W'(1);
      else if (do_pop && !do_push) fill <= fill - CNT_W'(1);
    end
  end

endmodule

// File: rtl/core/slxfp_back.sv
// Back end: status decision from the checksum result and the length limit, output register.
`timescale 1ns / 1ps

module slxfp_back
  import slxfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   q_empty,
  input  entry_t                 q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_kind,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic [7:0] max_len;
  logic [1:0] status;
  logic       load;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign q_pop = load;

  always_comb begin
    status = STATUS_OK;
    if (q_head.kind == KIND_STATUS) begin
      if (!q_head.chk_ok)             status = STATUS_BAD_CHK;
      else if (q_head.len > max_len)  status = STATUS_TOO_LARGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= q_head.kind;
      out_data <= {6'd0, q_head.len, status, q_head.data};
    end
  end

endmodule

// File: rtl/core/sync_length_xor_frame_parser.sv
// Top level of the sync/length/XOR frame parser.
//
//  channel   dir  handshake            contents
//  s_axis    in   s_tvalid/s_tready    rx byte in tdata[7:0]
//  m_axis    out  m_tvalid/m_tready    payload word or end-of-frame status
//  cfg       in   cfg_wr_en            max_payload_len
//
// One byte accepted per cycle while the word FIFO has room; a data or check byte's
// word is written into the FIFO at the accepting edge, then loaded into the output register.
// The front end stalls only when the word FIFO is full; the back end
// drains it into the output register whenever that register is free.
// Reset (rst, synchronous) returns to sync hunting, clears the FIFO and
// sets the length limit to 255.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser
  import slxfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // rx_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // payload_byte, frame_status, frame_length
  output logic                   m_tuser,   // item_kind
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data
);

  logic   push, q_full, q_empty, q_pop;
  entry_t push_entry, q_head;

  slxfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .q_full     (q_full),
    .in_ready   (s_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  slxfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  slxfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_data    (m_tdata)
  );

endmodule

// File: rtl/core/slxfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
`timescale 1ns / 1ps

module slxfp_checker
  import slxfp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[OUT_TDATA_W-1:8] == '0)
    else $error("payload word carries status or length");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_STATUS |->
      m_tdata[7:0] == 8'd0 && m_tdata[9:8] != 2'b11 && m_tdata[OUT_TDATA_W-1:18] == '0)
    else $error("malformed status word");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind sync_length_xor_frame_parser slxfp_checker u_slxfp_checker (.*);
